// ----- rtl/core/rsd_pkg.sv -----
package rsd_pkg;

  localparam int unsigned STREAM_SLOTS = 8;
  localparam int unsigned SLOT_W       = $clog2(STREAM_SLOTS);

  localparam int unsigned KIND_W       = 3;
  localparam int unsigned SSRC_W       = 32;
  localparam int unsigned PT_W         = 7;
  localparam int unsigned SLOT_FIELD_W = 3;
  localparam int unsigned MASK_W       = 64;
  localparam int unsigned TGT_W        = 3;

  localparam int unsigned IN_BITS    = SSRC_W + PT_W + SLOT_FIELD_W + 2 * MASK_W + 1;
  localparam int unsigned IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS   = 1 + TGT_W + 1 + 1;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [KIND_W-1:0] KIND_RTP     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RTCP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADD     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESP
  } rsd_state_e;

  typedef struct packed {
    logic              full;
    logic              learn;
    logic [SLOT_W-1:0] idx;
    logic              valid;
    logic [SSRC_W-1:0] ssrc;
    logic [MASK_W-1:0] mlo;
    logic [MASK_W-1:0] mhi;
    logic              raw;
  } rsd_wr_t;

  typedef struct packed {
    logic              valid;
    logic [SSRC_W-1:0] ssrc;
    logic [MASK_W-1:0] mlo;
    logic [MASK_W-1:0] mhi;
  } rsd_entry_t;

endpackage

// ----- rtl/core/rsd_slot_table.sv -----
module rsd_slot_table import rsd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rsd_wr_t                 wr_i,
  input  logic [SLOT_W-1:0]       rd_idx_i,
  output rsd_entry_t              rd_o,
  output logic [STREAM_SLOTS-1:0] valid_o,
  output logic [STREAM_SLOTS-1:0] raw_o,
  output logic [SLOT_W-1:0]       first_o
);

  logic [STREAM_SLOTS-1:0] valid_q;
  logic [STREAM_SLOTS-1:0] raw_q;
  logic [SSRC_W-1:0]       ssrc_q [STREAM_SLOTS];
  logic [MASK_W-1:0]       mlo_q  [STREAM_SLOTS];
  logic [MASK_W-1:0]       mhi_q  [STREAM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.full) begin
      valid_q[wr_i.idx] <= wr_i.valid;
    end
  end

  // Contents of a slot only matter while it is valid, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (wr_i.full) begin
      ssrc_q[wr_i.idx] <= wr_i.ssrc;
      mlo_q[wr_i.idx]  <= wr_i.mlo;
      mhi_q[wr_i.idx]  <= wr_i.mhi;
      raw_q[wr_i.idx]  <= wr_i.raw;
    end else if (wr_i.learn) begin
      ssrc_q[wr_i.idx] <= wr_i.ssrc;
    end
  end

  always_comb begin
    first_o = '0;
    for (int i = STREAM_SLOTS - 1; i >= 0; i--) begin
      if (valid_q[i]) begin
        first_o = SLOT_W'(i);
      end
    end
  end

  assign rd_o.valid = valid_q[rd_idx_i];
  assign rd_o.ssrc  = ssrc_q[rd_idx_i];
  assign rd_o.mlo   = mlo_q[rd_idx_i];
  assign rd_o.mhi   = mhi_q[rd_idx_i];
  assign valid_o    = valid_q;
  assign raw_o      = raw_q;

endmodule

// ----- rtl/core/rtp_stream_demultiplexer.sv -----
// Flow: an accepted add, remove or header passes ST_EXEC and then ST_RESP, which registers the
// result; a header that needs a table scan passes ST_SCAN between them, visiting the slots in
// order until one matches or the last is reached. A new transaction is taken only in ST_IDLE,
// once the last result is registered, and a stalled output holds ST_RESP. The scan uses the
// single SSRC compare and payload mask test that it shares across all slots.
// Reset is asynchronous and active low; it empties every slot and clears the raw-relay flag.
module rtp_stream_demultiplexer import rsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // ssrc[31:0], payload_type[38:32], slot[41:39], offered_low[105:42],
  // offered_high[169:106], relay_raw[170], zero fill above.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // kind[2:0]
  input  logic [KIND_W-1:0]     s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // delivered[0], target_slot[3:1], ssrc_learned[4], raw_relay_on[5], zero fill above.
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  rsd_state_e state_q, state_d;

  logic [SLOT_W-1:0]       idx_q, idx_d;
  logic [KIND_W-1:0]       kind_q;
  logic [SSRC_W-1:0]       ssrc_q;
  logic [PT_W-1:0]         pt_q;
  logic [SLOT_FIELD_W-1:0] slot_q;
  logic [MASK_W-1:0]       mlo_q;
  logic [MASK_W-1:0]       mhi_q;
  logic                    raw_q;
  logic                    sticky_q, sticky_d;
  logic                    del_q, del_d;
  logic [SLOT_W-1:0]       tgt_q, tgt_d;
  logic                    learn_q, learn_d;
  logic                    m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0]   m_data_q, m_data_d;

  rsd_wr_t                 wr;
  rsd_entry_t              ent;
  logic [STREAM_SLOTS-1:0] valid_vec;
  logic [STREAM_SLOTS-1:0] raw_vec;
  logic [SLOT_W-1:0]       first_idx;
  logic                    none_valid;
  logic                    one_valid;
  logic                    slot_in_range;
  logic                    ssrc_hit;
  logic                    pt_hit;
  logic                    s_accept;

  rsd_slot_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_idx_i (idx_q),
    .rd_o     (ent),
    .valid_o  (valid_vec),
    .raw_o    (raw_vec),
    .first_o  (first_idx)
  );

  assign s_accept      = s_axis_tvalid_i && s_axis_tready_o;
  assign none_valid    = (valid_vec == '0);
  assign one_valid     = !none_valid && ((valid_vec & (valid_vec - 1'b1)) == '0);
  assign slot_in_range = int'(slot_q) < STREAM_SLOTS;
  assign ssrc_hit      = (ent.ssrc != '0) && (ent.ssrc == ssrc_q);
  assign pt_hit        = pt_q[PT_W-1] ? ent.mhi[pt_q[PT_W-2:0]] : ent.mlo[pt_q[PT_W-2:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      sticky_q  <= 1'b0;
      del_q     <= 1'b0;
      tgt_q     <= '0;
      learn_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      sticky_q  <= sticky_d;
      del_q     <= del_d;
      tgt_q     <= tgt_d;
      learn_q   <= learn_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      kind_q <= s_axis_tuser_i;
      ssrc_q <= s_axis_tdata_i[31:0];
      pt_q   <= s_axis_tdata_i[38:32];
      slot_q <= s_axis_tdata_i[41:39];
      mlo_q  <= s_axis_tdata_i[105:42];
      mhi_q  <= s_axis_tdata_i[169:106];
      raw_q  <= s_axis_tdata_i[170];
    end
    m_data_q <= m_data_d;
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    sticky_d  = sticky_q;
    del_d     = del_q;
    tgt_d     = tgt_q;
    learn_d   = learn_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    wr        = '0;
    wr.idx    = SLOT_W'(slot_q);
    wr.ssrc   = ssrc_q;

    s_axis_tready_o = (state_q == ST_IDLE);

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        del_d   = 1'b0;
        tgt_d   = '0;
        learn_d = 1'b0;
        idx_d   = '0;
        state_d = ST_RESP;
        if (kind_q == KIND_ADD || kind_q == KIND_REMOVE) begin
          if (slot_in_range) begin
            wr.full = 1'b1;
            if (kind_q == KIND_ADD) begin
              wr.valid = 1'b1;
              wr.mlo   = mlo_q;
              wr.mhi   = mhi_q;
              wr.raw   = raw_q;
              if (raw_q) begin
                sticky_d = 1'b1;
              end
            end else begin
              wr.ssrc = '0;
            end
          end
        end else if (kind_q == KIND_RTP || kind_q == KIND_RTCP ||
                     kind_q == KIND_UNKNOWN) begin
          if (one_valid) begin
            if (kind_q == KIND_UNKNOWN) begin
              del_d = |(raw_vec & valid_vec);
              tgt_d = (|(raw_vec & valid_vec)) ? first_idx : '0;
            end else begin
              del_d = 1'b1;
              tgt_d = first_idx;
            end
          end else if (!none_valid && kind_q != KIND_UNKNOWN) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (ent.valid && ssrc_hit) begin
          del_d   = 1'b1;
          tgt_d   = idx_q;
          state_d = ST_RESP;
        end else if (ent.valid && kind_q == KIND_RTP && ent.ssrc == '0 && pt_hit) begin
          wr.learn = 1'b1;
          wr.idx   = idx_q;
          del_d    = 1'b1;
          learn_d  = 1'b1;
          tgt_d    = idx_q;
          state_d  = ST_RESP;
        end else if (idx_q == SLOT_W'(STREAM_SLOTS - 1)) begin
          state_d = ST_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = '0;
          m_data_d[0]   = del_q;
          m_data_d[3:1] = TGT_W'(tgt_q);
          m_data_d[4]   = learn_q;
          m_data_d[5]   = sticky_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ----- rtl/core/rsd_checker.sv -----
module rsd_checker import rsd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic [KIND_W-1:0]     s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic seen_raw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_raw_q <= 1'b0;
    end else if (m_axis_tvalid_o && m_axis_tready_i && m_axis_tdata_o[5]) begin
      seen_raw_q <= 1'b1;
    end
  end

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Only one transaction is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[4:1] == 4'd0)
    else $error("target or learned set without delivery");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && seen_raw_q |-> m_axis_tdata_o[5])
    else $error("raw relay flag dropped");

endmodule

bind rtp_stream_demultiplexer rsd_checker u_rsd_checker (.*);
